@@ hdl/dtcr_pkg.sv @@
// shared types, constants and register codes for depth to color registration
`timescale 1ns / 1ps
package dtcr_pkg;

  // field widths
  localparam int COL_W   = 9;
  localparam int ROW_W   = 9;
  localparam int Z_W     = 16;
  localparam int FIX_W   = 32;
  localparam int FOCAL_W = 31;
  localparam int SIZE_W  = 12;
  localparam int SCALE_W = 18;
  localparam int CFG_W   = 31;
  localparam int CFG_IDX_W = 3;

  // parameter defaults
  localparam int DEF_DEPTH_WIDTH  = 512;
  localparam int DEF_DEPTH_HEIGHT = 424;
  localparam int DEF_BASELINE     = 52;

  // divider shape: quotient bits and bits resolved per stage
  localparam int DIV_QW  = 32;
  localparam int DIV_BPS = 2;
  localparam int DIV_ST  = DIV_QW / DIV_BPS;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd6;

  // register reset values
  localparam logic [FOCAL_W-1:0] RST_FOCAL_X  = 31'd70844416;
  localparam logic [FOCAL_W-1:0] RST_FOCAL_Y  = 31'd70844416;
  localparam logic [FOCAL_W-1:0] RST_CENTER_X = 31'd62881792;
  localparam logic [FOCAL_W-1:0] RST_CENTER_Y = 31'd35356672;
  localparam logic [SIZE_W-1:0]  RST_WIDTH    = 12'd1280;
  localparam logic [SIZE_W-1:0]  RST_HEIGHT   = 12'd720;
  localparam logic [SCALE_W-1:0] RST_SCALE    = 18'd43691;

  // side data traveling alongside the dividers
  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [FIX_W-1:0] lut_x;
    logic [FIX_W-1:0] lut_y;
    logic [Z_W-1:0]   z;
    logic             neg_x;
    logic             neg_y;
    logic             ovf_x;
    logic             ovf_y;
    logic             zero_x;
    logic             zero_y;
  } meta_t;

  // input of the color mapping pipeline
  typedef struct packed {
    logic             vld;
    logic             ok;
    logic [FIX_W-1:0] lut_x;
    logic [FIX_W-1:0] lut_y;
    logic [FIX_W-1:0] off;
    logic [FIX_W-1:0] wx;
    logic [FIX_W-1:0] wy;
    logic [Z_W-1:0]   z;
  } map_in_t;

  // finished result
  typedef struct packed {
    logic              vld;
    logic              valid_res;
    logic [SIZE_W-1:0] col;
    logic [SIZE_W-1:0] row;
    logic [FIX_W-1:0]  wx;
    logic [FIX_W-1:0]  wy;
    logic [Z_W-1:0]    z;
  } result_t;

endpackage

@@ hdl/dtcr_div.sv @@
// pipelined restoring divider, a few quotient bits per stage
`timescale 1ns / 1ps
module dtcr_div #(
  parameter int DW  = 31,
  parameter int QW  = dtcr_pkg::DIV_QW,
  parameter int BPS = dtcr_pkg::DIV_BPS
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] num,
  input  logic [DW-1:0] rem_init,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);
  localparam int STAGES = QW / BPS;

  logic [DW-1:0] rem_r [STAGES];
  logic [QW-1:0] shf_r [STAGES];
  logic [DW-1:0] den_r [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [DW-1:0] rem_src;
    logic [QW-1:0] shf_src;
    logic [DW-1:0] den_src;
    logic [DW-1:0] rem_next;
    logic [QW-1:0] shf_next;

    if (g == 0) begin : g_first
      assign rem_src = rem_init;
      assign shf_src = num;
      assign den_src = den;
    end else begin : g_rest
      assign rem_src = rem_r[g-1];
      assign shf_src = shf_r[g-1];
      assign den_src = den_r[g-1];
    end

    always_comb begin : step
      logic [DW:0]   t;
      logic [DW-1:0] r;
      logic [QW-1:0] s;
      logic          qb;
      r = rem_src;
      s = shf_src;
      for (int k = 0; k < BPS; k++) begin
        t  = {r, s[QW-1]};
        qb = (t >= {1'b0, den_src});
        if (qb) begin
          t = t - {1'b0, den_src};
        end
        r = t[DW-1:0];
        s = {s[QW-2:0], qb};
      end
      rem_next = r;
      shf_next = s;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= rem_next;
        shf_r[g] <= shf_next;
        den_r[g] <= den_src;
      end
    end
  end

  assign quo = shf_r[STAGES-1];

endmodule

@@ hdl/dtcr_table.sv @@
// per-pixel correction table, one write and one registered read per cycle, the read only while en is high
`timescale 1ns / 1ps
module dtcr_table #(
  parameter int ENTRIES = dtcr_pkg::DEF_DEPTH_WIDTH * dtcr_pkg::DEF_DEPTH_HEIGHT,
  parameter int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic                       we,
  input  logic [AW-1:0]              addr,
  input  logic [dtcr_pkg::FIX_W-1:0] wdata_x,
  input  logic [dtcr_pkg::FIX_W-1:0] wdata_y,
  output logic [dtcr_pkg::FIX_W-1:0] rdata_x,
  output logic [dtcr_pkg::FIX_W-1:0] rdata_y
);
  import dtcr_pkg::*;

  logic [2*FIX_W-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= {wdata_x, wdata_y};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {rdata_x, rdata_y} <= mem[addr];
    end
  end

endmodule

@@ hdl/dtcr_map.sv @@
// color coordinate pipeline: offset add, focal multiply, center add and clamp, scale, bounds check
`timescale 1ns / 1ps
module dtcr_map (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  dtcr_pkg::map_in_t            din,
  input  logic [dtcr_pkg::FOCAL_W-1:0] focal_x,
  input  logic [dtcr_pkg::FOCAL_W-1:0] center_x,
  input  logic [dtcr_pkg::SIZE_W-1:0]  color_width,
  input  logic [dtcr_pkg::SIZE_W-1:0]  color_height,
  input  logic [dtcr_pkg::SCALE_W-1:0] output_scale,
  output dtcr_pkg::result_t            res
);
  import dtcr_pkg::*;

  localparam logic signed [50:0] LIM = 51'sd1 <<< 45;

  map_in_t st1, st2, st3, st4;
  logic signed [33:0] sum1;
  logic signed [65:0] prod2;
  logic signed [46:0] mx3;
  logic signed [65:0] sxp4;
  logic signed [50:0] syp4;

  logic signed [33:0] sum_next;
  logic signed [65:0] prod_next;
  logic signed [50:0] mxw;
  logic signed [46:0] mx_next;
  logic signed [65:0] sxp_next;
  logic signed [50:0] syp_next;
  logic signed [49:0] sx;
  logic signed [34:0] sy;
  logic               in_x, in_y, good;
  result_t            res_next;

  always_comb begin
    sum_next  = $signed({{2{din.lut_x[FIX_W-1]}}, din.lut_x}) + $signed({2'b00, din.off});
    prod_next = 66'(sum1) * 66'($signed({1'b0, focal_x}));
    mxw       = 51'(prod2 >>> 16) + $signed({20'd0, center_x});
    if (mxw > LIM) begin
      mx_next = 47'(LIM);
    end else if (mxw < -LIM) begin
      mx_next = 47'(-LIM);
    end else begin
      mx_next = 47'(mxw);
    end
    sxp_next = 66'(mx3) * 66'($signed({1'b0, output_scale}));
    syp_next = 51'($signed(st3.lut_y)) * 51'($signed({1'b0, output_scale}));
    sx   = 50'(sxp4 >>> 16);
    sy   = 35'(syp4 >>> 16);
    in_x = !sx[49] && (sx[48:0] < 49'({color_width, 16'd0}));
    in_y = !sy[34] && (sy[33:0] < 34'({color_height, 16'd0}));
    good = st4.ok && in_x && in_y;
    res_next.vld       = st4.vld;
    res_next.valid_res = good;
    res_next.col       = good ? sx[27:16] : '0;
    res_next.row       = good ? sy[27:16] : '0;
    res_next.wx        = good ? st4.wx : '0;
    res_next.wy        = good ? st4.wy : '0;
    res_next.z         = good ? st4.z : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st1.vld <= 1'b0;
      st2.vld <= 1'b0;
      st3.vld <= 1'b0;
      st4.vld <= 1'b0;
      res.vld <= 1'b0;
    end else if (en) begin
      st1   <= din;
      sum1  <= sum_next;
      st2   <= st1;
      prod2 <= prod_next;
      st3   <= st2;
      mx3   <= mx_next;
      st4   <= st3;
      sxp4  <= sxp_next;
      syp4  <= syp_next;
      res   <= res_next;
    end
  end

endmodule

@@ hdl/depth_to_color_registration.sv @@
// top level of the depth to color registration pipeline
`timescale 1ns / 1ps
// Depth to color registration. A load item (kind 0) writes the x and y
// correction terms of one depth pixel into the on-chip table; a map item
// (kind 1) reads that pixel's terms, adds baseline/depth to the x term, applies
// the color focal length and center, scales both coordinates and checks them
// against the color image size, and back-projects the pixel to world x and y.
// Every item, load or map, is taken while in_stall is low, so the block streams
// one item per clock. A map result passes the three radix-4 dividers (16
// stages each) that form baseline/depth and the two world coordinates, plus
// the front and back multiply stages. Load items give no result. A stalled
// output freezes the whole pipeline, and the input stall follows it in the
// same cycle. Table entries read before they were loaded return undefined
// data. Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must do so only while no item is in flight, the block does not enforce it.
module depth_to_color_registration #(
  parameter int DEPTH_WIDTH  = dtcr_pkg::DEF_DEPTH_WIDTH,
  parameter int DEPTH_HEIGHT = dtcr_pkg::DEF_DEPTH_HEIGHT,
  parameter int BASELINE     = dtcr_pkg::DEF_BASELINE
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [dtcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dtcr_pkg::CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [dtcr_pkg::COL_W-1:0]     pixel_col,
  input  logic [dtcr_pkg::ROW_W-1:0]     pixel_row,
  input  logic [dtcr_pkg::Z_W-1:0]       depth,
  input  logic [dtcr_pkg::FIX_W-1:0]     entry_x,
  input  logic [dtcr_pkg::FIX_W-1:0]     entry_y,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           valid_res,
  output logic [dtcr_pkg::SIZE_W-1:0]    color_col,
  output logic [dtcr_pkg::SIZE_W-1:0]    color_row,
  output logic [dtcr_pkg::FIX_W-1:0]     world_x,
  output logic [dtcr_pkg::FIX_W-1:0]     world_y,
  output logic [dtcr_pkg::Z_W-1:0]       world_z
);
  import dtcr_pkg::*;

  localparam int ENTRIES = DEPTH_WIDTH * DEPTH_HEIGHT;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // numerator of the baseline offset, Q16.16
  localparam logic [FIX_W-1:0] OFF_NUM = FIX_W'(BASELINE) << 16;

  // configuration registers
  logic [FOCAL_W-1:0] focal_x, focal_y, center_x, center_y;
  logic [SIZE_W-1:0]  color_width, color_height;
  logic [SCALE_W-1:0] output_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= RST_FOCAL_X;
      focal_y      <= RST_FOCAL_Y;
      center_x     <= RST_CENTER_X;
      center_y     <= RST_CENTER_Y;
      color_width  <= RST_WIDTH;
      color_height <= RST_HEIGHT;
      output_scale <= RST_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOCAL_X:  focal_x      <= cfg_data;
        REG_FOCAL_Y:  focal_y      <= cfg_data;
        REG_CENTER_X: center_x     <= cfg_data;
        REG_CENTER_Y: center_y     <= cfg_data;
        REG_WIDTH:    color_width  <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:   color_height <= cfg_data[SIZE_W-1:0];
        REG_SCALE:    output_scale <= cfg_data[SCALE_W-1:0];
        default: ; // indexes past the list are dropped
      endcase
    end
  end

  // global pipeline advance: everything moves unless a result is held
  result_t res;
  logic    adv;
  assign adv      = !(res.vld && out_stall);
  assign in_stall = !adv;

  // stage 0: pixel index and table access
  logic          in_image, accept;
  logic [AW-1:0] idx;
  logic [FIX_W-1:0] rd_x, rd_y;

  assign in_image = (int'(pixel_col) < DEPTH_WIDTH) && (int'(pixel_row) < DEPTH_HEIGHT);
  assign idx      = in_image ? AW'(int'(pixel_row) * DEPTH_WIDTH + int'(pixel_col)) : '0;
  assign accept   = in_valid && adv;

  dtcr_table #(
    .ENTRIES (ENTRIES),
    .AW      (AW)
  ) u_table (
    .clk     (clk),
    .en      (adv),
    .we      (accept && (kind == KIND_LOAD) && in_image),
    .addr    (idx),
    .wdata_x (entry_x),
    .wdata_y (entry_y),
    .rdata_x (rd_x),
    .rdata_y (rd_y)
  );

  // stage 1: captured map item
  logic             s1_vld, s1_ok;
  logic [COL_W-1:0] s1_col;
  logic [ROW_W-1:0] s1_row;
  logic [Z_W-1:0]   s1_z;

  // stage 2: pixel minus center, as sign and magnitude
  logic             s2_vld, s2_ok, s2_neg_x, s2_neg_y;
  logic [FIX_W-1:0] s2_mag_x, s2_mag_y, s2_lx, s2_ly;
  logic [Z_W-1:0]   s2_z;
  logic [32:0]      cterm_x, cterm_y;

  // stage 3: magnitude times depth
  logic             s3_vld, s3_ok, s3_neg_x, s3_neg_y;
  logic [47:0]      s3_px, s3_py;
  logic [FIX_W-1:0] s3_lx, s3_ly;
  logic [Z_W-1:0]   s3_z;

  assign cterm_x = {8'd0, s1_col, 16'd0} - {2'b00, center_x};
  assign cterm_y = {8'd0, s1_row, 16'd0} - {2'b00, center_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else if (adv) begin
      s1_vld   <= in_valid && (kind == KIND_MAP);
      s1_ok    <= in_image && (depth != '0);
      s1_col   <= pixel_col;
      s1_row   <= pixel_row;
      s1_z     <= depth;
      s2_vld   <= s1_vld;
      s2_ok    <= s1_ok;
      s2_neg_x <= cterm_x[32];
      s2_neg_y <= cterm_y[32];
      s2_mag_x <= cterm_x[32] ? FIX_W'(-cterm_x) : cterm_x[FIX_W-1:0];
      s2_mag_y <= cterm_y[32] ? FIX_W'(-cterm_y) : cterm_y[FIX_W-1:0];
      s2_lx    <= rd_x;
      s2_ly    <= rd_y;
      s2_z     <= s1_z;
      s3_vld   <= s2_vld;
      s3_ok    <= s2_ok;
      s3_neg_x <= s2_neg_x;
      s3_neg_y <= s2_neg_y;
      s3_px    <= {16'd0, s2_mag_x} * {32'd0, s2_z};
      s3_py    <= {16'd0, s2_mag_y} * {32'd0, s2_z};
      s3_lx    <= s2_lx;
      s3_ly    <= s2_ly;
      s3_z     <= s2_z;
    end
  end

  // dividers: baseline/depth and |numerator|/focal for both axes
  logic [FIX_W-1:0] off_q, wx_q, wy_q;

  dtcr_div #(.DW(Z_W)) u_div_off (
    .clk      (clk),
    .en       (adv),
    .num      (OFF_NUM),
    .rem_init ('0),
    .den      (s3_z),
    .quo      (off_q)
  );

  dtcr_div #(.DW(FOCAL_W)) u_div_x (
    .clk      (clk),
    .en       (adv),
    .num      ({s3_px[15:0], 16'd0}),
    .rem_init (s3_px[46:16]),
    .den      (focal_x),
    .quo      (wx_q)
  );

  dtcr_div #(.DW(FOCAL_W)) u_div_y (
    .clk      (clk),
    .en       (adv),
    .num      ({s3_py[15:0], 16'd0}),
    .rem_init (s3_py[46:16]),
    .den      (focal_y),
    .quo      (wy_q)
  );

  // side data delayed to meet the divider outputs
  meta_t meta_in;
  meta_t dly [DIV_ST];

  always_comb begin
    meta_in.vld    = s3_vld;
    meta_in.ok     = s3_ok;
    meta_in.lut_x  = s3_lx;
    meta_in.lut_y  = s3_ly;
    meta_in.z      = s3_z;
    meta_in.neg_x  = s3_neg_x;
    meta_in.neg_y  = s3_neg_y;
    // quotient would need more than 32 bits
    meta_in.ovf_x  = s3_px[47:16] >= {1'b0, focal_x};
    meta_in.ovf_y  = s3_py[47:16] >= {1'b0, focal_y};
    meta_in.zero_x = (s3_px == '0);
    meta_in.zero_y = (s3_py == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_ST; i++) begin
        dly[i].vld <= 1'b0;
      end
    end else if (adv) begin
      dly[0] <= meta_in;
      for (int i = 1; i < DIV_ST; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  // signed, saturated world coordinate from magnitude quotient
  function automatic logic [FIX_W-1:0] sat_world(logic [FIX_W-1:0] q, logic ovf,
                                                 logic neg, logic zero);
    logic [FIX_W-1:0] r;
    if (zero) begin
      r = '0;
    end else if (!neg) begin
      r = (ovf || q[FIX_W-1]) ? {1'b0, {(FIX_W-1){1'b1}}} : q;
    end else begin
      r = (ovf || (q > {1'b1, {(FIX_W-1){1'b0}}})) ? {1'b1, {(FIX_W-1){1'b0}}} : -q;
    end
    return r;
  endfunction

  map_in_t map_in;
  meta_t   md;
  assign md = dly[DIV_ST-1];

  always_comb begin
    map_in.vld   = md.vld;
    map_in.ok    = md.ok;
    map_in.lut_x = md.lut_x;
    map_in.lut_y = md.lut_y;
    map_in.off   = off_q;
    map_in.wx    = sat_world(wx_q, md.ovf_x, md.neg_x, md.zero_x);
    map_in.wy    = sat_world(wy_q, md.ovf_y, md.neg_y, md.zero_y);
    map_in.z     = md.z;
  end

  // color mapping, last stage is the output register
  dtcr_map u_map (
    .clk          (clk),
    .rst          (rst),
    .en           (adv),
    .din          (map_in),
    .focal_x      (focal_x),
    .center_x     (center_x),
    .color_width  (color_width),
    .color_height (color_height),
    .output_scale (output_scale),
    .res          (res)
  );

  assign out_valid = res.vld;
  assign valid_res = res.valid_res;
  assign color_col = res.col;
  assign color_row = res.row;
  assign world_x   = res.wx;
  assign world_y   = res.wy;
  assign world_z   = res.z;

endmodule

@@ hdl/dtcr_checker.sv @@
// port-level checks for depth to color registration, bound to the top level
`timescale 1ns / 1ps
module dtcr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           valid_res,
  input logic [dtcr_pkg::SIZE_W-1:0]    color_col,
  input logic [dtcr_pkg::SIZE_W-1:0]    color_row,
  input logic [dtcr_pkg::FIX_W-1:0]     world_x,
  input logic [dtcr_pkg::FIX_W-1:0]     world_y,
  input logic [dtcr_pkg::Z_W-1:0]       world_z
);
  import dtcr_pkg::*;

  // held result keeps its valid flag, world_x and color_col stable
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valid_res) && $stable(world_x)
      && $stable(color_col))
    else $error("held result changed");

  // input only stalls behind a held result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without held result");

  // rejected pixels carry all-zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> color_col == '0 && color_row == '0 && world_x == '0
      && world_y == '0 && world_z == '0)
    else $error("invalid result with nonzero fields");

  // a mapped pixel always has depth
  a_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> world_z != '0)
    else $error("valid result with zero depth");

  // pipeline empty after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind depth_to_color_registration dtcr_checker u_dtcr_checker (.*);

@@ bench/tb_depth_to_color_registration.sv @@
// self-checking testbench for the depth to color registration block
`timescale 1ns / 1ps
module tb_depth_to_color_registration;
  import dtcr_pkg::*;

  // one expected color mapping
  typedef struct {
    bit        hit;
    bit [11:0] col;
    bit [11:0] row;
    bit [31:0] wx;
    bit [31:0] wy;
    bit [15:0] z;
  } mapping_t;

  // scoreboard: mirrors the lookup tables and registers, queues the mappings it predicts
  class registration_board;
    bit [31:0] tab_x[int];
    bit [31:0] tab_y[int];
    longint    fx, fy, cx, cy, cw, ch, sc;
    mapping_t  pending[$];
    int        errors;

    function new();
      fx = RST_FOCAL_X; fy = RST_FOCAL_Y; cx = RST_CENTER_X; cy = RST_CENTER_Y;
      cw = RST_WIDTH; ch = RST_HEIGHT; sc = RST_SCALE;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_FOCAL_X:  fx = val;
        REG_FOCAL_Y:  fy = val;
        REG_CENTER_X: cx = val;
        REG_CENTER_Y: cy = val;
        REG_WIDTH:    cw = val[SIZE_W-1:0];
        REG_HEIGHT:   ch = val[SIZE_W-1:0];
        REG_SCALE:    sc = val[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // world coordinate from pixel, center, depth and focal length
    function longint unproject(longint pix, longint ctr, longint z, longint foc);
      longint num, q;
      num = (pix * 65536 - ctr) * z * 65536;
      if (foc == 0) begin
        if (num == 0) return 0;
        return (num > 0) ? 64'sd2147483647 : -64'sd2147483648;
      end
      q = num / foc;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q;
    endfunction

    function void note_item(logic k, logic [8:0] c, logic [8:0] r, logic [15:0] d,
                            logic [31:0] ex, logic [31:0] ey);
      bit       in_image;
      int       idx;
      longint   off, mx, sx, sy, lim;
      mapping_t m;
      in_image = (c < DEF_DEPTH_WIDTH) && (r < DEF_DEPTH_HEIGHT);
      idx = c + r * DEF_DEPTH_WIDTH;
      if (k == KIND_LOAD) begin
        if (in_image) begin
          tab_x[idx] = ex;
          tab_y[idx] = ey;
        end
        return;
      end
      m = '{default: 0};
      if (in_image && d != 0) begin
        lim = 64'sd1 <<< 45;
        off = (longint'(DEF_BASELINE) * 65536) / longint'(d);
        mx = (((longint'($signed(tab_x[idx])) + off) * fx) >>> 16) + cx;
        if (mx > lim) mx = lim;
        if (mx < -lim) mx = -lim;
        sx = (mx * sc) >>> 16;
        sy = (longint'($signed(tab_y[idx])) * sc) >>> 16;
        if (sx >= 0 && sx < cw * 65536 && sy >= 0 && sy < ch * 65536) begin
          m.hit = 1;
          m.col = 12'(sx >>> 16);
          m.row = 12'(sy >>> 16);
          m.wx  = 32'(unproject(c, cx, d, fx));
          m.wy  = 32'(unproject(r, cy, d, fy));
          m.z   = d;
        end
      end
      pending.insert(pending.size(), m);
    endfunction

    function void check_result(logic v, logic [11:0] c, logic [11:0] r, logic [31:0] wx,
                               logic [31:0] wy, logic [15:0] z);
      mapping_t m;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, nothing pending", $realtime);
        errors++;
        return;
      end
      m = pending.pop_front();
      if (v !== m.hit) begin
        $display("%0t: valid_res exp %0d got %0d", $realtime, m.hit, v); errors++;
      end
      if (c !== m.col) begin
        $display("%0t: color_col exp %0d got %0d", $realtime, m.col, c); errors++;
      end
      if (r !== m.row) begin
        $display("%0t: color_row exp %0d got %0d", $realtime, m.row, r); errors++;
      end
      if (wx !== m.wx) begin
        $display("%0t: world_x exp %h got %h", $realtime, m.wx, wx); errors++;
      end
      if (wy !== m.wy) begin
        $display("%0t: world_y exp %h got %h", $realtime, m.wy, wy); errors++;
      end
      if (z !== m.z) begin
        $display("%0t: world_z exp %0d got %0d", $realtime, m.z, z); errors++;
      end
    endfunction
  endclass

  logic                 clk, rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid, in_stall, kind;
  logic [COL_W-1:0]     pixel_col;
  logic [ROW_W-1:0]     pixel_row;
  logic [Z_W-1:0]       depth;
  logic [FIX_W-1:0]     entry_x, entry_y;
  logic                 out_valid, out_stall, valid_res;
  logic [SIZE_W-1:0]    color_col, color_row;
  logic [FIX_W-1:0]     world_x, world_y;
  logic [Z_W-1:0]       world_z;

  registration_board board;
  bit idle_on;     // random bursts of idling on both sides
  bit hold_req;    // ask the receiver for one long hold-off
  int loaded[$];   // table indexes that have been written

  depth_to_color_registration i_dut (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // generous overall limit
  initial begin
    #400000;
    $display("tb_depth_to_color_registration: FAIL");
    $finish;
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(valid_res, color_col, color_row, world_x, world_y, world_z);
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1;
        repeat (300) @(negedge clk);
        out_stall = 0;
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall = 1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall = 0;
      end
    end
  end

  // offer one item and wait until it is taken; returns at a falling edge
  task automatic send_item(logic k, logic [8:0] c, logic [8:0] r, logic [15:0] d,
                           logic [31:0] ex, logic [31:0] ey);
    kind = k; pixel_col = c; pixel_row = r; depth = d; entry_x = ex; entry_y = ey;
    in_valid = 1;
    do @(posedge clk); while (in_stall);
    board.note_item(k, c, r, d, ex, ey);
    if (k == KIND_LOAD && c < DEF_DEPTH_WIDTH && r < DEF_DEPTH_HEIGHT)
      loaded.insert(loaded.size(), int'(c + r * DEF_DEPTH_WIDTH));
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    board.set_reg(idx, val);
  endtask

  // wait for every pending mapping, then for the pipeline to empty of loads
  task automatic drain();
    in_valid = 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic load_config(int f_x, int f_y, int c_x, int c_y, int w, int h, int s);
    write_reg(REG_FOCAL_X, CFG_W'(f_x));
    write_reg(REG_FOCAL_Y, CFG_W'(f_y));
    write_reg(REG_CENTER_X, CFG_W'(c_x));
    write_reg(REG_CENTER_Y, CFG_W'(c_y));
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    write_reg(REG_SCALE, CFG_W'(s));
  endtask

  // random traffic: mostly plausible entries and maps of loaded pixels, some noise
  task automatic random_items(int count);
    int          idx;
    logic [31:0] ex, ey;
    logic [15:0] d;
    repeat (count) begin
      if (loaded.size() == 0 || $urandom_range(0, 9) < 4) begin
        if ($urandom_range(0, 9) < 7) begin
          ex = $urandom_range(0, 104000) - 52000;
          ey = $urandom_range(0, 75000000);
        end else begin
          ex = $urandom;
          ey = $urandom;
        end
        send_item(KIND_LOAD, 9'($urandom_range(0, 511)), 9'($urandom_range(0, 450)),
                  16'($urandom), ex, ey);
      end else if ($urandom_range(0, 9) < 8) begin
        idx = loaded[$urandom_range(0, loaded.size() - 1)];
        d = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
        send_item(KIND_MAP, 9'(idx % DEF_DEPTH_WIDTH), 9'(idx / DEF_DEPTH_WIDTH), d,
                  $urandom, $urandom);
      end else begin
        // pixel outside the depth image, its table data is never used
        send_item(KIND_MAP, 9'($urandom_range(0, 511)), 9'($urandom_range(424, 511)),
                  16'($urandom), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    board = new();
    idle_on = 1; hold_req = 0;
    rst = 1; cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; kind = 0; pixel_col = '0; pixel_row = '0; depth = '0;
    entry_x = '0; entry_y = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: table extremes, depth extremes, outside pixels
    send_item(KIND_LOAD, 0, 0, 0, 32'h0000_0000, 32'h0000_0000);
    send_item(KIND_LOAD, 511, 423, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_item(KIND_LOAD, 5, 5, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(KIND_LOAD, 320, 200, 0, 32'h0000_1000, 32'h0200_0000);
    send_item(KIND_LOAD, 100, 300, 0, 32'hFFFF_8000, 32'h0100_0000);
    send_item(KIND_LOAD, 100, 450, 0, 32'h1234_5678, 32'h1234_5678); // ignored
    send_item(KIND_MAP, 0, 0, 16'd0, 0, 0);           // no depth
    send_item(KIND_MAP, 0, 0, 16'd1, 0, 0);
    send_item(KIND_MAP, 0, 0, 16'hFFFF, 0, 0);
    send_item(KIND_MAP, 511, 423, 16'hFFFF, 0, 0);
    send_item(KIND_MAP, 5, 5, 16'd1, 0, 0);
    send_item(KIND_MAP, 320, 200, 16'd1000, 0, 0);
    send_item(KIND_MAP, 320, 200, 16'd1, 0, 0);
    send_item(KIND_MAP, 100, 300, 16'd2500, 0, 0);
    send_item(KIND_MAP, 511, 511, 16'd500, 0, 0);     // row outside depth image
    send_item(KIND_MAP, 300, 424, 16'd500, 0, 0);
    random_items(120);

    // long hold-off at the receiver while items keep coming
    hold_req = 1;
    random_items(80);
    drain();

    // extremes, zero focal length among them
    load_config(0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 4095, 4095, 131072);
    send_item(KIND_MAP, 320, 200, 16'd1000, 0, 0);
    send_item(KIND_MAP, 0, 0, 16'hFFFF, 0, 0);
    random_items(80);
    drain();

    // zero width, no scale
    load_config(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 0, 0, 1, 0);
    random_items(40);
    drain();

    // back to plausible optics, last stretch without idling
    load_config(RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y, 1920, 1080, 65536);
    random_items(100);
    drain();
    idle_on = 0;
    load_config(RST_FOCAL_X, RST_FOCAL_Y, RST_CENTER_X, RST_CENTER_Y, RST_WIDTH, RST_HEIGHT,
                RST_SCALE);
    random_items(80);
    drain();

    if (board.errors == 0 && board.pending.size() == 0)
      $display("tb_depth_to_color_registration: PASS");
    else
      $display("tb_depth_to_color_registration: FAIL");
    $finish;
  end
endmodule
